// ----- rtl/small_array_sort_search_engine_top_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef SMALL_ARRAY_SORT_SEARCH_ENGINE_TOP_DEFINES_SVH
`define SMALL_ARRAY_SORT_SEARCH_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SASE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SASE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SASE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SASE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/sase_pkg.sv -----
package sase_pkg;

    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;
    localparam int MIDX_W = 4;

    typedef logic signed [WIDTH-1:0] t_word;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [OP_W-1:0]         t_op;
    typedef logic [STAT_W-1:0]       t_status;
    typedef logic [MIDX_W-1:0]       t_midx;

    localparam t_op OP_CLEAR   = 3'd0;
    localparam t_op OP_APPEND  = 3'd1;
    localparam t_op OP_SEARCH  = 3'd2;
    localparam t_op OP_SORT    = 3'd3;
    localparam t_op OP_REVERSE = 3'd4;
    localparam t_op OP_READ    = 3'd5;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

    typedef struct packed {
        t_status status;
        logic    found;
        t_midx   midx;
        t_word   value;
        logic    last;
    } t_result;

endpackage

// ----- rtl/sase_if.sv -----
interface sase_in_if;
    import sase_pkg::*;

    logic  valid;
    logic  ready;
    t_op   operation;
    t_word operand_value;

    modport source (output valid, output operation, output operand_value, input ready);
    modport sink   (input valid, input operation, input operand_value, output ready);
endinterface

interface sase_out_if;
    import sase_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    logic    found;
    t_midx   match_index;
    t_word   element_value;
    logic    last_item;

    modport source (output valid, output status, output found, output match_index,
                    output element_value, output last_item, input ready);
    modport sink   (input valid, input status, input found, input match_index,
                    input element_value, input last_item, output ready);
endinterface

// ----- rtl/sase_ram.sv -----
module sase_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data_a <= r_mem[i_rd_addr_a];
        r_rd_data_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

// ----- rtl/sase_cmp.sv -----
module sase_cmp (
    input  sase_pkg::t_word    i_a,
    input  sase_pkg::t_word    i_b,
    output sase_pkg::t_cmp_res o_res
);
    import sase_pkg::*;

    // signed compare, shared by search (equality) and sort (less than)
    always_comb begin
        o_res.eq = (i_a == i_b);
        o_res.lt = (i_a < i_b);
    end

endmodule

// ----- rtl/small_array_sort_search_engine_top.sv -----
// Small array sort and search engine.
// i_in carries one command per transaction (operation, operand_value); o_out carries
// result transactions (status, found, match_index, element_value, last_item).
// Every command but read out answers one transaction with last_item set; read out
// answers one per stored element, first to last, last_item on the final one, or one
// with empty status on an empty store. Codes 6 and 7 are dropped without a result.
// Commands run one at a time on a single comparator and a two-read-port store;
// i_in.ready is high only while the sequencer is idle. Search visits elements
// first to last until the first match; sort and reverse do nothing when fewer
// than two elements are stored; reverse swaps pairs from both ends; read out
// waits for each element's registered read before it answers.
// Results leave through an output register, so the next command is taken while
// the last result still waits. A stall on o_out holds the sequencer at its next
// result. Reset (synchronous) empties the store (count zero); no clearing pass.
module small_array_sort_search_engine_top (
    input logic        i_clk,
    input logic        i_rst_n,
    sase_in_if.sink    i_in,
    sase_out_if.source o_out
);
    import sase_pkg::*;

    `include "small_array_sort_search_engine_top_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_RESP,
        S_SRCH_W, S_SRCH_C,
        S_SRT_LW, S_SRT_LD, S_SRT_JW, S_SRT_C, S_SRT_WI,
        S_REV_W, S_REV_A, S_REV_B,
        S_RD_W, S_RD_O
    } t_state;

    t_state  r_state, n_state;
    t_cnt    r_count, n_count;
    t_idx    r_i, n_i;
    t_idx    r_j, n_j;
    t_word   r_val, n_val;
    t_word   r_cur, n_cur;
    t_result r_res, n_res;
    t_result r_out;
    logic    r_out_valid;

    logic     wr_en;
    t_idx     wr_addr;
    t_word    wr_data;
    t_word    rd_a, rd_b;
    t_word    cmp_a, cmp_b;
    t_cmp_res cmp;
    logic     slot_free;
    logic     emit;
    t_result  emit_res;
    logic     last_i, last_j;

    sase_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (r_i),
        .i_rd_addr_b (r_j),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign cmp_a = (r_state == S_SRT_C) ? rd_b  : rd_a;
    assign cmp_b = (r_state == S_SRT_C) ? r_cur : r_val;

    sase_cmp u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp)
    );

    assign slot_free = !r_out_valid || o_out.ready;
    assign last_i    = (t_cnt'(r_i) == r_count - 1'b1);
    assign last_j    = (t_cnt'(r_j) == r_count - 1'b1);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_val    = r_val;
        n_cur    = r_cur;
        n_res    = r_res;
        wr_en    = 1'b0;
        wr_addr  = r_i;
        wr_data  = r_cur;
        emit     = 1'b0;
        emit_res = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_val      = i_in.operand_value;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_i        = '0;
                    n_state    = S_RESP;
                    unique case (i_in.operation)
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_APPEND: begin
                            if (r_count == t_cnt'(DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = t_idx'(r_count);
                                wr_data = i_in.operand_value;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count != '0) begin
                                n_state = S_SRCH_W;
                            end
                        end
                        OP_SORT: begin
                            if (r_count >= t_cnt'(2)) begin
                                n_state = S_SRT_LW;
                            end
                        end
                        OP_REVERSE: begin
                            if (r_count >= t_cnt'(2)) begin
                                n_j     = t_idx'(r_count - 1'b1);
                                n_state = S_REV_W;
                            end
                        end
                        OP_READ: begin
                            if (r_count == '0) begin
                                n_res.status = ST_EMPTY;
                            end else begin
                                n_state = S_RD_W;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SRCH_W: n_state = S_SRCH_C;
            S_SRCH_C: begin
                if (cmp.eq) begin
                    n_res.found = 1'b1;
                    n_res.midx  = t_midx'(r_i);
                    n_state     = S_RESP;
                end else if (last_i) begin
                    n_state = S_RESP;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SRCH_W;
                end
            end
            S_SRT_LW: n_state = S_SRT_LD;
            S_SRT_LD: begin
                n_cur   = rd_a;
                n_j     = r_i + 1'b1;
                n_state = S_SRT_JW;
            end
            S_SRT_JW: n_state = S_SRT_C;
            S_SRT_C: begin
                // r_cur stands for the element at position i
                if (cmp.lt) begin
                    wr_en   = 1'b1;
                    wr_addr = r_j;
                    wr_data = r_cur;
                    n_cur   = rd_b;
                end
                if (last_j) begin
                    n_state = S_SRT_WI;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SRT_JW;
                end
            end
            S_SRT_WI: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = r_cur;
                if (t_cnt'(r_i) + t_cnt'(2) == r_count) begin
                    n_state = S_RESP;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SRT_LW;
                end
            end
            S_REV_W: n_state = S_REV_A;
            S_REV_A: begin
                wr_en   = 1'b1;
                wr_addr = r_i;
                wr_data = rd_b;
                n_cur   = rd_a;
                n_state = S_REV_B;
            end
            S_REV_B: begin
                wr_en   = 1'b1;
                wr_addr = r_j;
                wr_data = r_cur;
                if (t_cnt'(r_i) + t_cnt'(2) < t_cnt'(r_j)) begin
                    n_i     = r_i + 1'b1;
                    n_j     = r_j - 1'b1;
                    n_state = S_REV_W;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_RD_W: n_state = S_RD_O;
            S_RD_O: begin
                if (slot_free) begin
                    emit           = 1'b1;
                    emit_res       = '0;
                    emit_res.value = rd_a;
                    emit_res.last  = last_i;
                    if (last_i) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_RD_W;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_val <= n_val;
        r_cur <= n_cur;
        r_res <= n_res;
        if (emit) begin
            r_out <= emit_res;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_out.status;
    assign o_out.found         = r_out.found;
    assign o_out.match_index   = r_out.midx;
    assign o_out.element_value = r_out.value;
    assign o_out.last_item     = r_out.last;

    `SASE_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= t_cnt'(DEPTH), "count above depth")
    `SASE_ASSERT(a_wr_range, i_clk, i_rst_n, wr_en |-> (t_cnt'(wr_addr) <= r_count),
        "store write beyond element count")
    `SASE_ASSERT(a_sort_pair, i_clk, i_rst_n, (r_state == S_SRT_C) |-> (r_j > r_i),
        "sort inner index not above outer index")
    `SASE_ASSERT(a_rev_pair, i_clk, i_rst_n, (r_state == S_REV_B) |-> (r_i < r_j),
        "reverse indices crossed")
    `SASE_ASSERT_NEXT(a_clear, i_clk, i_rst_n,
        i_in.valid && i_in.ready && (i_in.operation == OP_CLEAR), r_count == '0,
        "clear left elements")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import sase_pkg::*;

    localparam t_op   OP_RSVD_A   = 3'd6;
    localparam t_op   OP_RSVD_B   = 3'd7;
    localparam t_word WORD_MIN    = {1'b1, {(WIDTH-1){1'b0}}};
    localparam t_word WORD_MAX    = {1'b0, {(WIDTH-1){1'b1}}};
    localparam int    USEFUL_CMDS = 140;
    localparam int    TAIL_CYCLES = 400;
    localparam int    CYCLE_LIMIT = 400000;

    typedef struct {
        t_op         op;
        t_word       val;
        int unsigned gap;
        bit          drain;
    } t_cmd_slot;

    logic i_clk;
    logic i_rst_n;

    sase_in_if  in_if ();
    sase_out_if out_if ();

    small_array_sort_search_engine_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // shadow of the engine
    t_word       shadow_store [DEPTH];
    int          shadow_count;
    t_result     awaited_results [$];

    t_cmd_slot   pending_cmds [$];
    t_cmd_slot   cur_cmd;
    bit          have_cmd;
    int unsigned gap_left;
    bit          tx_calm;

    int unsigned stall_left;
    bit          rx_calm;

    bit          cmd_fire;
    bit          res_fire;
    int          cmds_total;
    int          cmds_accepted;
    int          useful_cmds;
    int          fail_count;
    int          cycle_count;
    t_result     exp_r;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic apply_command(t_op op, t_word val);
        t_result r;
        int      n;
        int      i;
        int      j;
        t_word   t;
        bit      hit;
        r      = '0;
        r.last = 1'b1;
        n      = shadow_count;
        hit    = 1'b0;
        case (op)
            OP_CLEAR: begin
                shadow_count = 0;
                awaited_results.push_back(r);
            end
            OP_APPEND: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_store[n] = val;
                    shadow_count    = n + 1;
                end
                awaited_results.push_back(r);
            end
            OP_SEARCH: begin
                for (i = 0; i < n; i++) begin
                    if (!hit && shadow_store[i] == val) begin
                        hit    = 1'b1;
                        r.found = 1'b1;
                        r.midx  = t_midx'(i);
                    end
                end
                awaited_results.push_back(r);
            end
            OP_SORT: begin
                for (i = 0; i < n; i++) begin
                    for (j = i; j < n; j++) begin
                        if (shadow_store[j] < shadow_store[i]) begin
                            t               = shadow_store[j];
                            shadow_store[j] = shadow_store[i];
                            shadow_store[i] = t;
                        end
                    end
                end
                awaited_results.push_back(r);
            end
            OP_REVERSE: begin
                for (i = 0, j = n - 1; i < j; i++, j--) begin
                    t               = shadow_store[i];
                    shadow_store[i] = shadow_store[j];
                    shadow_store[j] = t;
                end
                awaited_results.push_back(r);
            end
            OP_READ: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                    awaited_results.push_back(r);
                end else begin
                    for (i = 0; i < n; i++) begin
                        r.value = shadow_store[i];
                        r.last  = (i == n - 1);
                        awaited_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string field, logic [WIDTH-1:0] exp_v, logic [WIDTH-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s mismatch: expected %0h, got %0h", field, exp_v, got_v);
            fail_count++;
        end
    endtask

    task automatic queue_cmd(t_op op, t_word val, bit drain);
        t_cmd_slot c;
        c.op    = op;
        c.val   = val;
        c.gap   = tx_calm ? 0 : $urandom_range(0, 8);
        c.drain = drain;
        pending_cmds.push_back(c);
        if (op <= OP_READ) useful_cmds++;
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(0, 5))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2, 3: return t_word'(int'($urandom_range(0, 8)) - 4);
            default: return t_word'($urandom);
        endcase
    endfunction

    // transaction monitor and shadow update
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            cmd_fire = i_rst_n && in_if.valid === 1'b1 && in_if.ready === 1'b1;
            res_fire = i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1;
            if (cmd_fire) begin
                apply_command(in_if.operation, in_if.operand_value);
                cmds_accepted++;
            end
            if (res_fire) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected result transaction, value %0h", out_if.element_value);
                    fail_count++;
                end else begin
                    exp_r = awaited_results.pop_front();
                    check_field("status", WIDTH'(exp_r.status), WIDTH'(out_if.status));
                    check_field("found", WIDTH'(exp_r.found), WIDTH'(out_if.found));
                    check_field("match_index", WIDTH'(exp_r.midx),
                        WIDTH'(out_if.match_index));
                    check_field("element_value", exp_r.value, out_if.element_value);
                    check_field("last_item", WIDTH'(exp_r.last), WIDTH'(out_if.last_item));
                end
            end
        end
    end

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!(in_if.valid && !cmd_fire)) begin
            if (!have_cmd && pending_cmds.size() > 0) begin
                cur_cmd  = pending_cmds.pop_front();
                have_cmd = 1'b1;
                gap_left = cur_cmd.gap;
            end
            if (have_cmd && gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (have_cmd && (!cur_cmd.drain || awaited_results.size() == 0)) begin
                in_if.operation     <= cur_cmd.op;
                in_if.operand_value <= cur_cmd.val;
                in_if.valid         <= 1'b1;
                have_cmd = 1'b0;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result sink backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (res_fire) begin
                if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
                stall_left = rx_calm ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_word seq_vals [$];
        t_word v;
        int    n_app;
        int    n_ops;
        bit    first_seq;

        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.operation      = OP_CLEAR;
        in_if.operand_value  = '0;
        out_if.ready         = 1'b0;
        cmd_fire             = 1'b0;
        res_fire             = 1'b0;
        have_cmd             = 1'b0;
        shadow_count         = 0;
        stall_left           = $urandom_range(0, 8);
        rx_calm              = 1'b0;
        tx_calm              = 1'b0;
        first_seq            = 1'b1;

        // directed: empty store, extremes, duplicates, reserved codes
        queue_cmd(OP_READ, '0, 0);
        queue_cmd(OP_SEARCH, '0, 0);
        queue_cmd(OP_SORT, '0, 0);
        queue_cmd(OP_REVERSE, '0, 0);
        queue_cmd(OP_APPEND, WORD_MIN, 0);
        queue_cmd(OP_APPEND, WORD_MAX, 0);
        queue_cmd(OP_APPEND, '0, 0);
        queue_cmd(OP_APPEND, t_word'(-1), 0);
        queue_cmd(OP_APPEND, t_word'(1), 0);
        queue_cmd(OP_APPEND, WORD_MAX, 0);
        queue_cmd(OP_SEARCH, WORD_MAX, 0);
        queue_cmd(OP_SEARCH, WORD_MIN, 0);
        queue_cmd(OP_SEARCH, t_word'(5), 0);
        queue_cmd(OP_RSVD_A, WORD_MAX, 0);
        queue_cmd(OP_RSVD_B, WORD_MIN, 0);
        queue_cmd(OP_READ, '0, 0);
        queue_cmd(OP_SORT, '0, 0);
        queue_cmd(OP_READ, '0, 0);
        queue_cmd(OP_REVERSE, '0, 0);
        queue_cmd(OP_READ, '0, 1);
        queue_cmd(OP_CLEAR, '0, 0);
        queue_cmd(OP_APPEND, t_word'(42), 0);
        queue_cmd(OP_REVERSE, '0, 0);
        queue_cmd(OP_READ, '0, 0);

        // random: mostly clear/fill/operate sequences, some noise
        while (useful_cmds < USEFUL_CMDS) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(2, 5))
                    queue_cmd(t_op'($urandom_range(0, 7)), t_word'($urandom), 0);
            end else begin
                queue_cmd(OP_CLEAR, '0, $urandom_range(0, 5) == 0);
                seq_vals.delete();
                n_app = first_seq ? DEPTH + 2 : $urandom_range(0, DEPTH + 2);
                repeat (n_app) begin
                    v = pick_value();
                    queue_cmd(OP_APPEND, v, 0);
                    if (seq_vals.size() < DEPTH) seq_vals.push_back(v);
                end
                if (first_seq) queue_cmd(OP_SEARCH, seq_vals[DEPTH-1], 0);
                first_seq = 1'b0;
                n_ops = $urandom_range(2, 6);
                repeat (n_ops) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            if (seq_vals.size() > 0 && $urandom_range(0, 2) != 0)
                                v = seq_vals[$urandom_range(0, seq_vals.size() - 1)];
                            else
                                v = pick_value();
                            queue_cmd(OP_SEARCH, v, 0);
                        end
                        1: queue_cmd(OP_SORT, t_word'($urandom), 0);
                        2: queue_cmd(OP_REVERSE, t_word'($urandom), 0);
                        3, 4: queue_cmd(OP_READ, t_word'($urandom), 0);
                        default: queue_cmd(OP_APPEND, pick_value(), 0);
                    endcase
                end
            end
        end
        cmds_total = pending_cmds.size();

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmds_accepted < cmds_total || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sase_pkg.sv
rtl/sase_if.sv
rtl/sase_ram.sv
rtl/sase_cmp.sv
rtl/small_array_sort_search_engine_top.sv
tb/sv/tb_top.sv
